>>> rtl/subpel_block_sad_uni_bi_assert.svh
// Assertion macros for the sub-pixel block SAD checker.
`ifndef SUBPEL_BLOCK_SAD_UNI_BI_ASSERT_SVH
`define SUBPEL_BLOCK_SAD_UNI_BI_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SBSAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SBSAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sbsad_pkg.sv
// Shared types and constants for the sub-pixel block SAD engine.
package sbsad_pkg;

    localparam int SAMPLE_W   = 15;
    localparam int WEIGHT_W   = 5;
    localparam int WEIGHTS_W  = 4 * WEIGHT_W;
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
    localparam int WSUM_W     = PROD_W + 2;
    localparam int SAD_W      = 31;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int ROUND_SINGLE = 8;
    localparam int SHIFT_SINGLE = 4;
    localparam int ROUND_BIDIR  = 16;
    localparam int SHIFT_BIDIR  = 5;

    localparam int PRED_W = WSUM_W - SHIFT_SINGLE;
    localparam int HALF_W = WSUM_W - SHIFT_BIDIR;

    localparam logic [SAD_W-1:0] SAD_MAX = {SAD_W{1'b1}};

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_BIDIR_MODE     = 2'd0;
    localparam logic [1:0] REG_WEIGHTS_FIRST  = 2'd1;
    localparam logic [1:0] REG_WEIGHTS_SECOND = 2'd2;

    localparam logic [WEIGHTS_W-1:0] WEIGHTS_RESET = WEIGHTS_W'(16);

    // 2x2 neighborhood: 0 upper left, 1 upper right, 2 lower left, 3 lower right
    typedef logic [3:0][SAMPLE_W-1:0] nbhd_t;

endpackage

>>> rtl/subpel_block_sad_uni_bi.sv
// Sub-pixel block SAD: takes one pixel word per cycle with its 2x2 reference
// neighborhood (two neighborhoods in bidirectional mode), forms the bilinear
// prediction, and accumulates |cur - pred| into a 31-bit saturating sum. The
// word marked last_of_block yields one result word (sum and clip flag) and
// clears the sum. Throughput is one word per cycle while no result word waits on
// m_ready; a word passes an input register, a weighted-sum register, a difference
// register and the accumulator, which also registers the result word.
// The whole pipeline holds while a result word waits on m_ready.
module subpel_block_sad_uni_bi (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sbsad_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sbsad_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sbsad_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    // pixel words
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sbsad_pkg::SAMPLE_W-1:0]   s_cur_pixel,
    input  logic [sbsad_pkg::SAMPLE_W-1:0]   s_ref_a_upper_left,
    input  logic [sbsad_pkg::SAMPLE_W-1:0]   s_ref_a_upper_right,
    input  logic [sbsad_pkg::SAMPLE_W-1:0]   s_ref_a_lower_left,
    input  logic [sbsad_pkg::SAMPLE_W-1:0]   s_ref_a_lower_right,
    input  logic [sbsad_pkg::SAMPLE_W-1:0]   s_ref_b_upper_left,
    input  logic [sbsad_pkg::SAMPLE_W-1:0]   s_ref_b_upper_right,
    input  logic [sbsad_pkg::SAMPLE_W-1:0]   s_ref_b_lower_left,
    input  logic [sbsad_pkg::SAMPLE_W-1:0]   s_ref_b_lower_right,
    input  logic                             s_last_of_block,
    // result words
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sbsad_pkg::SAD_W-1:0]      m_block_sad,
    output logic                             m_sad_saturated
);

    logic                              bidir_mode_reg;
    logic [sbsad_pkg::WEIGHTS_W-1:0]   weights_first_reg;
    logic [sbsad_pkg::WEIGHTS_W-1:0]   weights_second_reg;
    logic                              cfg_write;

    logic                              advance;

    logic                              s1_valid_reg;
    logic [sbsad_pkg::SAMPLE_W-1:0]    s1_cur_reg;
    sbsad_pkg::nbhd_t                  s1_ref_a_reg;
    sbsad_pkg::nbhd_t                  s1_ref_b_reg;
    logic                              s1_last_reg;

    logic [sbsad_pkg::WSUM_W-1:0]      wsum_a;
    logic [sbsad_pkg::WSUM_W-1:0]      wsum_b;

    logic                              s2_valid_reg;
    logic [sbsad_pkg::SAMPLE_W-1:0]    s2_cur_reg;
    logic [sbsad_pkg::WSUM_W-1:0]      s2_wsum_a_reg;
    logic [sbsad_pkg::WSUM_W-1:0]      s2_wsum_b_reg;
    logic                              s2_last_reg;

    logic [sbsad_pkg::WSUM_W-1:0]      rnd_single;
    logic [sbsad_pkg::WSUM_W-1:0]      rnd_a;
    logic [sbsad_pkg::WSUM_W-1:0]      rnd_b;
    logic [sbsad_pkg::PRED_W-1:0]      pred;
    logic [sbsad_pkg::PRED_W-1:0]      cur_ext;
    logic [sbsad_pkg::PRED_W-1:0]      diff;

    logic                              s3_valid_reg;
    logic [sbsad_pkg::PRED_W-1:0]      s3_diff_reg;
    logic                              s3_last_reg;

    logic [sbsad_pkg::SAD_W:0]         total;
    logic [sbsad_pkg::SAD_W-1:0]       acc_sum;
    logic                              ovf_sum;

    logic [sbsad_pkg::SAD_W-1:0]       acc_reg;
    logic [sbsad_pkg::SAD_W-1:0]       acc_next;
    logic                              ovf_reg;
    logic                              ovf_next;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic [sbsad_pkg::SAD_W-1:0]       m_block_sad_reg;
    logic [sbsad_pkg::SAD_W-1:0]       m_block_sad_next;
    logic                              m_sad_saturated_reg;
    logic                              m_sad_saturated_next;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bidir_mode_reg     <= 1'b0;
            weights_first_reg  <= sbsad_pkg::WEIGHTS_RESET;
            weights_second_reg <= sbsad_pkg::WEIGHTS_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                sbsad_pkg::REG_BIDIR_MODE:     bidir_mode_reg     <= pwdata[0];
                sbsad_pkg::REG_WEIGHTS_FIRST:  weights_first_reg  <= pwdata[sbsad_pkg::WEIGHTS_W-1:0];
                sbsad_pkg::REG_WEIGHTS_SECOND: weights_second_reg <= pwdata[sbsad_pkg::WEIGHTS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sbsad_pkg::REG_BIDIR_MODE:
                prdata = sbsad_pkg::APB_DATA_W'(bidir_mode_reg);
            sbsad_pkg::REG_WEIGHTS_FIRST:
                prdata = sbsad_pkg::APB_DATA_W'(weights_first_reg);
            sbsad_pkg::REG_WEIGHTS_SECOND:
                prdata = sbsad_pkg::APB_DATA_W'(weights_second_reg);
            default:
                prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // hold every stage while the result word is not taken
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // ---------------- stage 1: input register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_cur_reg   <= s_cur_pixel;
            s1_ref_a_reg <= {s_ref_a_lower_right, s_ref_a_lower_left,
                             s_ref_a_upper_right, s_ref_a_upper_left};
            s1_ref_b_reg <= {s_ref_b_lower_right, s_ref_b_lower_left,
                             s_ref_b_upper_right, s_ref_b_upper_left};
            s1_last_reg  <= s_last_of_block;
        end
    end

    // ---------------- stage 2: weighted sums ----------------
    sbsad_wsum u_wsum_a (
        .weights (weights_first_reg),
        .samples (s1_ref_a_reg),
        .wsum    (wsum_a)
    );

    sbsad_wsum u_wsum_b (
        .weights (weights_second_reg),
        .samples (s1_ref_b_reg),
        .wsum    (wsum_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_cur_reg    <= s1_cur_reg;
            s2_wsum_a_reg <= wsum_a;
            s2_wsum_b_reg <= wsum_b;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // ---------------- stage 3: prediction and absolute difference ----------------
    always_comb begin
        rnd_single = s2_wsum_a_reg + sbsad_pkg::WSUM_W'(sbsad_pkg::ROUND_SINGLE);
        rnd_a      = s2_wsum_a_reg + sbsad_pkg::WSUM_W'(sbsad_pkg::ROUND_BIDIR);
        rnd_b      = s2_wsum_b_reg + sbsad_pkg::WSUM_W'(sbsad_pkg::ROUND_BIDIR);
        if (bidir_mode_reg) begin
            pred = sbsad_pkg::PRED_W'(rnd_a[sbsad_pkg::WSUM_W-1:sbsad_pkg::SHIFT_BIDIR])
                 + sbsad_pkg::PRED_W'(rnd_b[sbsad_pkg::WSUM_W-1:sbsad_pkg::SHIFT_BIDIR]);
        end else begin
            pred = rnd_single[sbsad_pkg::WSUM_W-1:sbsad_pkg::SHIFT_SINGLE];
        end
        cur_ext = sbsad_pkg::PRED_W'(s2_cur_reg);
        diff    = (cur_ext >= pred) ? (cur_ext - pred) : (pred - cur_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (advance) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s3_diff_reg <= diff;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ---------------- stage 4: saturating accumulate and result ----------------
    always_comb begin
        total   = {1'b0, acc_reg} + (sbsad_pkg::SAD_W + 1)'(s3_diff_reg);
        acc_sum = total[sbsad_pkg::SAD_W] ? sbsad_pkg::SAD_MAX : total[sbsad_pkg::SAD_W-1:0];
        ovf_sum = ovf_reg || total[sbsad_pkg::SAD_W];

        acc_next             = acc_reg;
        ovf_next             = ovf_reg;
        m_valid_next         = m_valid_reg;
        m_block_sad_next     = m_block_sad_reg;
        m_sad_saturated_next = m_sad_saturated_reg;

        if (advance) begin
            m_valid_next = 1'b0;
            if (s3_valid_reg) begin
                if (s3_last_reg) begin
                    // emit the block sum, then clear for the next block
                    m_valid_next         = 1'b1;
                    m_block_sad_next     = acc_sum;
                    m_sad_saturated_next = ovf_sum;
                    acc_next             = '0;
                    ovf_next             = 1'b0;
                end else begin
                    acc_next = acc_sum;
                    ovf_next = ovf_sum;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_block_sad_reg     <= m_block_sad_next;
        m_sad_saturated_reg <= m_sad_saturated_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_block_sad     = m_block_sad_reg;
    assign m_sad_saturated = m_sad_saturated_reg;

endmodule

>>> rtl/sbsad_wsum.sv
// Weighted 2x2 neighborhood sum with four packed 5-bit weights.
module sbsad_wsum (
    input  logic [sbsad_pkg::WEIGHTS_W-1:0] weights,
    input  sbsad_pkg::nbhd_t                samples,
    output logic [sbsad_pkg::WSUM_W-1:0]    wsum
);

    logic [3:0][sbsad_pkg::PROD_W-1:0] prod;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k] = sbsad_pkg::PROD_W'(weights[k*sbsad_pkg::WEIGHT_W +: sbsad_pkg::WEIGHT_W])
                    * sbsad_pkg::PROD_W'(samples[k]);
        end
        wsum = sbsad_pkg::WSUM_W'(prod[0]) + sbsad_pkg::WSUM_W'(prod[1])
             + sbsad_pkg::WSUM_W'(prod[2]) + sbsad_pkg::WSUM_W'(prod[3]);
    end

endmodule

>>> rtl/sbsad_checker.sv
// Port-level checker for the sub-pixel block SAD engine, bound to the top level.
`include "subpel_block_sad_uni_bi_assert.svh"

module sbsad_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [sbsad_pkg::SAD_W-1:0]      m_block_sad,
    input logic                             m_sad_saturated
);

    // a stalled result word keeps its value
    `SBSAD_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_block_sad) && $stable(m_sad_saturated), "result word changed while stalled")

    // a clipped sum always reads as the maximum
    `SBSAD_ASSERT_NOW(a_sat_at_max, m_valid && m_sad_saturated, m_block_sad == sbsad_pkg::SAD_MAX, "saturation flag without a full sum")

    // input backpressure only while a result word waits
    `SBSAD_ASSERT_NOW(a_ready_free, !s_ready, m_valid && !m_ready, "input stalled with no pending result")

    // no result word straight out of reset
    `SBSAD_ASSERT_NOW(a_reset_quiet, $past(!aresetn), !m_valid, "result word right after reset")

endmodule

bind subpel_block_sad_uni_bi sbsad_checker u_sbsad_checker (.*);

>>> tb/tb_subpel_block_sad_uni_bi.sv
// Self-checking testbench for the sub-pixel block SAD engine: directed and random pixel words.
module tb_subpel_block_sad_uni_bi;
    import sbsad_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_WORDS  = 196;

    localparam logic [1:0]          REG_UNUSED = 2'd3;
    localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = {SAMPLE_W{1'b1}};
    localparam logic [WEIGHTS_W-1:0] WTS_ALL   = {WEIGHTS_W{1'b1}};
    localparam logic [WEIGHTS_W-1:0] WTS_NONE  = '0;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] cur;
        nbhd_t               ref_a;
        nbhd_t               ref_b;
        logic                last;
    } pix_word_t;

    typedef struct packed {
        logic [SAD_W-1:0] sad;
        logic             clipped;
    } block_sum_t;

    // Mirror of the running block sum; queues the sums each closing word should produce.
    class block_sad_mirror;
        logic                 bidir;
        logic [WEIGHTS_W-1:0] wts_a;
        logic [WEIGHTS_W-1:0] wts_b;
        longint unsigned      acc;
        logic                 clipped;
        block_sum_t           sums_due[$];
        int                   words_taken;
        int                   sums_checked;
        int                   failures;

        function new();
            bidir        = 1'b0;
            wts_a        = WEIGHTS_RESET;
            wts_b        = WEIGHTS_RESET;
            acc          = 0;
            clipped      = 1'b0;
            words_taken  = 0;
            sums_checked = 0;
            failures     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_BIDIR_MODE:     bidir = value[0];
                REG_WEIGHTS_FIRST:  wts_a = value[WEIGHTS_W-1:0];
                REG_WEIGHTS_SECOND: wts_b = value[WEIGHTS_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned weigh(logic [WEIGHTS_W-1:0] wts, nbhd_t nb);
            longint unsigned s;
            longint unsigned wk;
            s = 0;
            for (int k = 0; k < 4; k++) begin
                wk = wts[WEIGHT_W*k +: WEIGHT_W];
                s += wk * nb[k];
            end
            return s;
        endfunction

        function void take_word(pix_word_t w);
            longint unsigned pred;
            longint unsigned diff;
            longint unsigned total;
            words_taken++;
            if (bidir)
                pred = ((weigh(wts_a, w.ref_a) + ROUND_BIDIR) >> SHIFT_BIDIR)
                     + ((weigh(wts_b, w.ref_b) + ROUND_BIDIR) >> SHIFT_BIDIR);
            else
                pred = (weigh(wts_a, w.ref_a) + ROUND_SINGLE) >> SHIFT_SINGLE;
            diff  = (w.cur >= pred) ? (w.cur - pred) : (pred - w.cur);
            total = acc + diff;
            if (total > SAD_MAX) begin
                acc     = SAD_MAX;
                clipped = 1'b1;
            end else begin
                acc = total;
            end
            if (w.last) begin
                sums_due.push_back('{sad: acc[SAD_W-1:0], clipped: clipped});
                acc     = 0;
                clipped = 1'b0;
            end
        endfunction

        function void match_sum(logic [SAD_W-1:0] sad, logic sat);
            block_sum_t want;
            sums_checked++;
            if (sums_due.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result word: sad %0d saturated %0b", sad, sat);
                return;
            end
            want = sums_due.pop_front();
            if (want.sad !== sad || want.clipped !== sat) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("block sum mismatch: expected sad %0d sat %0b, got sad %0d sat %0b",
                             want.sad, want.clipped, sad, sat);
            end
        endfunction

        function int pending();
            return sums_due.size();
        endfunction
    endclass

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_cur_pixel         = '0;
    logic [SAMPLE_W-1:0]   s_ref_a_upper_left  = '0;
    logic [SAMPLE_W-1:0]   s_ref_a_upper_right = '0;
    logic [SAMPLE_W-1:0]   s_ref_a_lower_left  = '0;
    logic [SAMPLE_W-1:0]   s_ref_a_lower_right = '0;
    logic [SAMPLE_W-1:0]   s_ref_b_upper_left  = '0;
    logic [SAMPLE_W-1:0]   s_ref_b_upper_right = '0;
    logic [SAMPLE_W-1:0]   s_ref_b_lower_left  = '0;
    logic [SAMPLE_W-1:0]   s_ref_b_lower_right = '0;
    logic                  s_last_of_block     = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [SAD_W-1:0]      m_block_sad;
    logic                  m_sad_saturated;

    block_sad_mirror sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int configs_done   = 0;

    subpel_block_sad_uni_bi DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cur_pixel        (s_cur_pixel),
        .s_ref_a_upper_left (s_ref_a_upper_left),
        .s_ref_a_upper_right(s_ref_a_upper_right),
        .s_ref_a_lower_left (s_ref_a_lower_left),
        .s_ref_a_lower_right(s_ref_a_lower_right),
        .s_ref_b_upper_left (s_ref_b_upper_left),
        .s_ref_b_upper_right(s_ref_b_upper_right),
        .s_ref_b_lower_left (s_ref_b_lower_left),
        .s_ref_b_lower_right(s_ref_b_lower_right),
        .s_last_of_block    (s_last_of_block),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_block_sad        (m_block_sad),
        .m_sad_saturated    (m_sad_saturated)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.match_sum(m_block_sad, m_sad_saturated);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d sums still due", CYCLE_LIMIT, sb.pending());
        $display("tb: failure");
        $finish;
    end

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default:   begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
    endtask

    task automatic push_word(input pix_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_cur_pixel         <= w.cur;
        s_ref_a_upper_left  <= w.ref_a[0];
        s_ref_a_upper_right <= w.ref_a[1];
        s_ref_a_lower_left  <= w.ref_a[2];
        s_ref_a_lower_right <= w.ref_a[3];
        s_ref_b_upper_left  <= w.ref_b[0];
        s_ref_b_upper_right <= w.ref_b[1];
        s_ref_b_lower_left  <= w.ref_b[2];
        s_ref_b_lower_right <= w.ref_b[3];
        s_last_of_block     <= w.last;
        do @(posedge aclk); while (!s_ready);
        sb.take_word(w);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold until every due sum is out and the pipe has flushed non-closing words.
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(logic bidir, logic [WEIGHTS_W-1:0] wa,
                                logic [WEIGHTS_W-1:0] wb);
        logic [APB_DATA_W-1:0] v;
        wait_idle();
        v = $urandom;
        v[0] = bidir;
        cfg_write(REG_BIDIR_MODE, v);
        v = $urandom;
        v[WEIGHTS_W-1:0] = wa;
        cfg_write(REG_WEIGHTS_FIRST, v);
        v = $urandom;
        v[WEIGHTS_W-1:0] = wb;
        cfg_write(REG_WEIGHTS_SECOND, v);
        cfg_write(REG_UNUSED, $urandom);
        configs_done++;
    endtask

    function automatic pix_word_t make_word(logic [SAMPLE_W-1:0] cur, nbhd_t a, nbhd_t b,
                                            logic last);
        pix_word_t w;
        w.cur   = cur;
        w.ref_a = a;
        w.ref_b = b;
        w.last  = last;
        return w;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return SAMPLE_TOP;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic pix_word_t random_word(logic last);
        pix_word_t w;
        w.cur = pick_sample();
        for (int j = 0; j < 4; j++) begin
            w.ref_a[j] = pick_sample();
            w.ref_b[j] = pick_sample();
        end
        w.last = last;
        return w;
    endfunction

    task automatic run_random(idle_mode_t mode, logic bidir, logic [WEIGHTS_W-1:0] wa,
                              logic [WEIGHTS_W-1:0] wb);
        int sent;
        int len;
        apply_config(bidir, wa, wb);
        set_idling(mode);
        sent = 0;
        while (sent < PHASE_WORDS) begin
            len = ($urandom_range(7) == 0) ? 64 : $urandom_range(1, 16);
            for (int k = 0; k < len; k++)
                push_word(random_word(k == len - 1));
            sent += len;
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        nbhd_t top4;
        nbhd_t zero4;
        top4  = {4{SAMPLE_TOP}};
        zero4 = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset weights: prediction equals the upper-left sample.
        set_idling(IDLE_NONE);
        push_word(make_word('0, zero4, zero4, 1'b1));
        push_word(make_word(SAMPLE_TOP, zero4, zero4, 1'b1));
        push_word(make_word('0, top4, zero4, 1'b0));
        push_word(make_word(SAMPLE_TOP, top4, top4, 1'b1));
        push_word(make_word(15'd5, {45'd0, 15'd9}, zero4, 1'b0));
        push_word(make_word(15'd9, {45'd0, 15'd5}, top4, 1'b1));
        s_valid <= 1'b0;

        // Two references, half-weight rounding.
        apply_config(1'b1, WEIGHTS_RESET, WEIGHTS_RESET);
        push_word(make_word('0, {45'd0, 15'd1}, {45'd0, 15'd1}, 1'b1));
        push_word(make_word(SAMPLE_TOP, top4, top4, 1'b1));
        push_word(make_word('0, zero4, zero4, 1'b1));
        s_valid <= 1'b0;

        apply_config(1'b0, WTS_ALL, WTS_ALL);
        push_word(make_word('0, top4, zero4, 1'b1));
        push_word(make_word(SAMPLE_TOP, zero4, top4, 1'b1));
        push_word(make_word(SAMPLE_TOP, top4, top4, 1'b1));
        s_valid <= 1'b0;

        apply_config(1'b1, WTS_ALL, WTS_NONE);
        push_word(make_word('0, top4, top4, 1'b0));
        push_word(make_word(SAMPLE_TOP, top4, zero4, 1'b1));
        s_valid <= 1'b0;

        run_random(IDLE_NONE, 1'b0, WEIGHTS_W'($urandom), WEIGHTS_W'($urandom));
        run_random(IDLE_SEND, 1'b1, WEIGHTS_W'($urandom), WEIGHTS_W'($urandom));
        run_random(IDLE_RECV, 1'b1, WTS_ALL, WTS_ALL);
        run_random(IDLE_BOTH, 1'b0, WTS_NONE, WEIGHTS_W'($urandom));
        run_random(IDLE_NONE, 1'b1, WTS_NONE, WTS_NONE);
        run_random(IDLE_SEND, 1'b0, WTS_ALL, WEIGHTS_W'($urandom));
        run_random(IDLE_RECV, 1'b0, WEIGHTS_W'($urandom), WEIGHTS_W'($urandom));
        run_random(IDLE_BOTH, 1'b1, WEIGHTS_W'($urandom), WEIGHTS_W'($urandom));

        wait_idle();
        if (sb.pending() != 0) begin
            sb.failures += sb.pending();
            $display("%0d block sums never arrived", sb.pending());
        end
        $display("summary: %0d pixel words sent, %0d block sums compared", sb.words_taken,
                 sb.sums_checked);
        $display("summary: %0d register settings, single and bidirectional, %0d errors",
                 configs_done, sb.failures);
        if (sb.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
